// ===== rtl/wsrm_pkg.sv =====
// ----------------------------------------------------------------------------
// wsrm_pkg: shared types and constants for the star/dot pattern matcher
// Item layouts, request codes and the links between position cells.
// ----------------------------------------------------------------------------
`default_nettype none

package wsrm_pkg;

  localparam int PATTERN_MAX = 32;
  localparam int POS_W       = $clog2(PATTERN_MAX + 1);  // holds 0..PATTERN_MAX
  localparam int IDX_W       = $clog2(PATTERN_MAX);

  localparam logic [7:0] ANY_SYMBOL = 8'h2E;  // '.'

  // configuration register indexes
  localparam logic REG_PATTERN_LENGTH = 1'b0;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_BYTE  = 2'd1,
    REQ_EMPTY = 2'd2
  } req_e_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [4:0] token_index;
    logic [7:0] token_symbol;
    logic       token_starred;
    logic [7:0] text_symbol;
    logic       last_symbol;
  } in_item_t;

  typedef struct packed {
    logic verdict_valid;
    logic matched;
  } out_item_t;

  // broadcast to every cell
  typedef struct packed {
    logic       step;      // advance the active set on a text byte
    logic       rearm;     // back to "only position zero active"
    logic [7:0] text_sym;
  } cell_ctl_t;

  // handed from cell i to cell i+1
  typedef struct packed {
    logic close;  // closure reaches the next position through a starred token
    logic adv;    // non-starred token matched: next position becomes active
  } cell_link_t;

endpackage : wsrm_pkg

`default_nettype wire

// ===== rtl/wildcard_star_regex_matcher.sv =====
// ----------------------------------------------------------------------------
// wildcard_star_regex_matcher: whole-text matcher for '.' and starred tokens
// A row of position cells tracks which pattern prefixes the text can reach.
// ----------------------------------------------------------------------------
// Usage:
//   Load pattern tokens with req_type LOAD items (token_index, token_symbol,
//   token_starred), then write the token count to pattern_length over the
//   APB port (offset 0). Stream text as BYTE items; last_symbol marks the
//   final byte. An EMPTY item ends the pending text (an empty text when no
//   byte came). Every item yields exactly one result item; verdict_valid is
//   set only for items that end a text, with matched giving the outcome.
//   The set rearms to position zero after each verdict.
// Throughput: one item per cycle when not stalled. Every cell updates in
//   parallel; star closure ripples down the cell row in the same cycle.
// Pipeline: the first stage register holds the position set of a finished
//   text; its final closure runs into the output register, which drives
//   out_valid.
// Reset: pattern_length clears to 0 and only position zero is active; the
//   token store keeps whatever it holds until loaded.
// Stall: while out_ready is low the result and staged items hold; in_ready
//   stays high until both the stage and the output register are full.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_star_regex_matcher
  import wsrm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input items
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  // result items
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  // APB configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  logic [POS_W-1:0] len_r;
  logic [POS_W-1:0] len_eff;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_PATTERN_LENGTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (cfg_wr) begin
      len_r <= pwdata[POS_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_PATTERN_LENGTH) ? {{(32-POS_W){1'b0}}, len_r} : '0;

  // lengths beyond the store act as a full store
  assign len_eff = (len_r > POS_W'(PATTERN_MAX)) ? POS_W'(PATTERN_MAX) : len_r;

  // --------------------------------------------------------------------------
  // handshake
  // --------------------------------------------------------------------------
  logic out_free;
  logic s1_valid_r;
  logic accept;

  assign out_free = ~out_valid | out_ready;
  assign in_ready = ~s1_valid_r | out_free;
  assign accept   = in_valid & in_ready;

  // --------------------------------------------------------------------------
  // request decode
  // --------------------------------------------------------------------------
  cell_ctl_t ctl;
  logic      is_load;
  logic      is_byte;
  logic      is_empty;

  always_comb begin
    is_load  = 1'b0;
    is_byte  = 1'b0;
    is_empty = 1'b0;
    unique case (in_data.req_type)
      REQ_LOAD:  is_load  = 1'b1;
      REQ_BYTE:  is_byte  = 1'b1;
      REQ_EMPTY: is_empty = 1'b1;
      default: ;  // unused code: no effect
    endcase
  end

  assign ctl.text_sym = in_data.text_symbol;
  assign ctl.step     = accept & is_byte;
  assign ctl.rearm    = accept & ((is_byte & in_data.last_symbol) | is_empty);

  // --------------------------------------------------------------------------
  // cell row: cell i owns token i and active position i
  // --------------------------------------------------------------------------
  cell_link_t                 link [PATTERN_MAX+1];
  logic [PATTERN_MAX:0]       act_raw;
  logic [PATTERN_MAX:0]       act_next;
  logic [PATTERN_MAX:0]       le_mask;
  logic [PATTERN_MAX-1:0]     stars;
  logic [PATTERN_MAX-1:0]     pass;
  logic                       tail_r;   // position past the last token

  assign link[0] = '0;

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    logic en;
    assign en = (POS_W'(i) < len_eff);
    assign pass[i] = stars[i] | ~en;

    wsrm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .home      ((i == 0) ? 1'b1 : 1'b0),
      .en        (en),
      .load_en   (accept & is_load & (in_data.token_index == IDX_W'(i))),
      .load_sym  (in_data.token_symbol),
      .load_star (in_data.token_starred),
      .ctl       (ctl),
      .link_in   (link[i]),
      .link_out  (link[i+1]),
      .active    (act_raw[i]),
      .star      (stars[i]),
      .next_act  (act_next[i])
    );
  end

  for (genvar j = 0; j <= PATTERN_MAX; j++) begin : g_mask
    assign le_mask[j] = (POS_W'(j) <= len_eff);
  end

  assign act_raw[PATTERN_MAX]  = tail_r;
  assign act_next[PATTERN_MAX] = link[PATTERN_MAX].adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_r <= 1'b0;
    end else if (ctl.rearm) begin
      tail_r <= 1'b0;
    end else if (ctl.step) begin
      tail_r <= act_next[PATTERN_MAX];
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: set of a finished text plus a snapshot of the pass mask
  // --------------------------------------------------------------------------
  logic                   s1_verdict_r;
  logic [PATTERN_MAX:0]   s1_set_r;
  logic [PATTERN_MAX-1:0] s1_pass_r;
  logic                   s1_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (out_free) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_verdict_r <= ctl.rearm;
      // next set is already zero past the length; the raw set is masked
      s1_set_r     <= is_empty ? (act_raw & le_mask) : act_next;
      s1_pass_r    <= pass;
    end
  end

  wsrm_close u_close (
    .set  (s1_set_r),
    .pass (s1_pass_r),
    .hit  (s1_hit)
  );

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  logic      out_valid_r;
  out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free & s1_valid_r) begin
      out_data_r.verdict_valid <= s1_verdict_r;
      out_data_r.matched       <= s1_verdict_r & s1_hit;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule : wildcard_star_regex_matcher

`default_nettype wire

// ===== rtl/wsrm_cell.sv =====
// ----------------------------------------------------------------------------
// wsrm_cell: one pattern position
// Holds a token and the active bit of its position; closes over stars and
// matches the current text byte, passing results on to its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module wsrm_cell
  import wsrm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       home,       // active after reset / rearm
  input  wire logic       en,         // position lies below pattern length
  input  wire logic       load_en,
  input  wire logic [7:0] load_sym,
  input  wire logic       load_star,
  input  wire cell_ctl_t  ctl,
  input  wire cell_link_t link_in,
  output cell_link_t      link_out,
  output logic            active,     // raw stored active bit
  output logic            star,
  output logic            next_act    // active bit after this byte
);

  logic [7:0] sym_r;
  logic       star_r;
  logic       active_r;
  logic       active_nxt;
  logic       closed;
  logic       hit;

  assign closed = active_r | link_in.close;
  assign hit    = en & closed & ((sym_r == ANY_SYMBOL) | (sym_r == ctl.text_sym));

  assign link_out.close = closed & star_r & en;
  assign link_out.adv   = hit & ~star_r;

  assign next_act = (hit & star_r) | link_in.adv;
  assign active   = active_r;
  assign star     = star_r;

  always_comb begin
    active_nxt = active_r;
    if (ctl.rearm) begin
      active_nxt = home;
    end else if (ctl.step) begin
      active_nxt = next_act;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= home;
    end else begin
      active_r <= active_nxt;
    end
  end

  // token store, undefined until loaded
  always_ff @(posedge clk) begin
    if (load_en) begin
      sym_r  <= load_sym;
      star_r <= load_star;
    end
  end

endmodule : wsrm_cell

`default_nettype wire

// ===== rtl/wsrm_close.sv =====
// ----------------------------------------------------------------------------
// wsrm_close: final closure for a verdict
// Ripples a position set through starred tokens to the end of the pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module wsrm_close
  import wsrm_pkg::*;
(
  input  wire logic [PATTERN_MAX:0]   set,   // zero above pattern length
  input  wire logic [PATTERN_MAX-1:0] pass,  // starred, or past pattern length
  output logic                        hit
);

  logic [PATTERN_MAX:0] reach;

  assign reach[0] = set[0];

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_step
    assign reach[i+1] = set[i+1] | (reach[i] & pass[i]);
  end

  // positions past the pattern length pass through, so the top bit equals
  // the bit at the pattern length
  assign hit = reach[PATTERN_MAX];

endmodule : wsrm_close

`default_nettype wire

// ===== test/wildcard_star_regex_matcher_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wildcard_star_regex_matcher_tb: self-checking bench for the pattern matcher
// Loads token patterns, sets pattern_length over APB and streams texts, first
// directed cases and then random phases of mostly well-formed texts. A
// position-set predictor works out every result item and a monitor checks
// them in order, with random idling on both channels.
// ----------------------------------------------------------------------------
module wildcard_star_regex_matcher_tb;
  import wsrm_pkg::*;

  localparam int         CYCLE_LIMIT = 400000;
  localparam int         TEXT_ITEMS  = 600;       // random text items to send
  localparam int         ITEM_W      = $bits(in_item_t);
  localparam logic [2:0] LENGTH_ADDR = {REG_PATTERN_LENGTH, 2'b00};
  localparam logic [1:0] REQ_UNUSED  = 2'd3;      // no-op request code
  localparam logic [7:0] SYM_A       = 8'h61;
  localparam logic [7:0] SYM_B       = 8'h62;
  localparam logic [7:0] SYM_C       = 8'h63;
  localparam logic [7:0] SYM_D       = 8'h64;
  localparam logic [PATTERN_MAX:0] HOME_SET = {{PATTERN_MAX{1'b0}}, 1'b1};

  // DUT signals
  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // predictor state: token store, active positions, length register
  logic [7:0]           token_sym  [PATTERN_MAX];
  logic                 token_star [PATTERN_MAX];
  logic [PATTERN_MAX:0] active_set;
  logic [5:0]           pat_len;

  // stimulus-side copy of the pattern, used only to shape texts
  logic [7:0] stim_sym  [PATTERN_MAX];
  logic       stim_star [PATTERN_MAX];

  out_item_t verdict_q[$];   // expected result items, oldest first
  int        errors      = 0;
  int        cycle_count = 0;
  int        text_items  = 0;
  int        idle_pct;       // chance (%) of an idle cycle on either side

  wildcard_star_regex_matcher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("wildcard_star_regex_matcher regression: fail");
      $finish;
    end
  end

  // receiver stalls at random, changed on the falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= idle_pct);
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Epsilon closure: an active starred token may be skipped, so the next
  // position is reachable too. Ripples low to high within one call.
  function automatic logic [PATTERN_MAX:0] star_closure(logic [PATTERN_MAX:0] s, int len);
    for (int i = 0; i < len; i++)
      if (s[i] && token_star[i]) s[i+1] = 1'b1;
    return s;
  endfunction

  // Applies one accepted item to the predictor and returns its result item.
  function automatic out_item_t match_step(in_item_t it);
    out_item_t            r;
    logic [PATTERN_MAX:0] cur;
    logic [PATTERN_MAX:0] nxt;
    int                   len;
    r   = '0;
    len = (pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len);
    case (it.req_type)
      REQ_LOAD: begin
        // mid-text loads keep the active set
        token_sym[it.token_index]   = it.token_symbol;
        token_star[it.token_index]  = it.token_starred;
      end
      REQ_BYTE: begin
        cur = star_closure(active_set, len);
        nxt = '0;
        for (int i = 0; i < len; i++) begin
          if (cur[i] && (token_sym[i] == ANY_SYMBOL || token_sym[i] == it.text_symbol)) begin
            if (token_star[i]) nxt[i] = 1'b1;   // starred: stay for more repeats
            else nxt[i+1] = 1'b1;
          end
        end
        if (it.last_symbol) begin
          nxt             = star_closure(nxt, len);
          r.verdict_valid = 1'b1;
          r.matched       = nxt[len];
          active_set      = HOME_SET;
        end else begin
          active_set = nxt;
        end
      end
      REQ_EMPTY: begin
        // ends whatever text is pending, an empty one if no byte came
        cur             = star_closure(active_set, len);
        r.verdict_valid = 1'b1;
        r.matched       = cur[len];
        active_set      = HOME_SET;
      end
      default: ;  // unused code: no change, idle result item
    endcase
    return r;
  endfunction

  // Monitor: register writes and accepted items feed the predictor first,
  // then any result taken this edge is checked against the oldest entry.
  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (!rst_n) begin
      pat_len     = '0;
      active_set  = HOME_SET;
    end else begin
      if (psel && penable && pwrite && pready && paddr == LENGTH_ADDR)
        pat_len = pwdata[5:0];
      if (in_valid && in_ready)
        verdict_q.push_back(match_step(in_data));
      if (out_valid && out_ready) begin
        got = out_data;
        if (verdict_q.size() == 0) begin
          $display("%0t: result item with none expected: verdict_valid %0b matched %0b",
                   $time, got.verdict_valid, got.matched);
          errors++;
        end else begin
          want = verdict_q.pop_front();
          if (got.verdict_valid !== want.verdict_valid) begin
            $display("%0t: verdict_valid mismatch: expected %0b actual %0b",
                     $time, want.verdict_valid, got.verdict_valid);
            errors++;
          end
          if (got.matched !== want.matched) begin
            $display("%0t: matched mismatch: expected %0b actual %0b",
                     $time, want.matched, got.matched);
            errors++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers. All tasks start and end on a falling edge.
  // --------------------------------------------------------------------------

  // Random gap, then hold valid until the item is taken. Valid is never
  // dropped between back-to-back items.
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // fields that the request does not use are left random
  function automatic in_item_t random_item(logic [1:0] req);
    in_item_t it;
    it          = ITEM_W'($urandom);
    it.req_type = req;
    return it;
  endfunction

  task automatic send_load(logic [4:0] idx, logic [7:0] sym, logic starred);
    in_item_t it;
    it               = random_item(REQ_LOAD);
    it.token_index   = idx;
    it.token_symbol  = sym;
    it.token_starred = starred;
    stim_sym[idx]    = sym;
    stim_star[idx]   = starred;
    send_item(it);
  endtask

  task automatic send_byte(logic [7:0] b, logic last);
    in_item_t it;
    it             = random_item(REQ_BYTE);
    it.text_symbol = b;
    it.last_symbol = last;
    text_items++;
    send_item(it);
  endtask

  task automatic send_end();
    text_items++;
    send_item(random_item(REQ_EMPTY));
  endtask

  // Lower valid and wait until every expected result is back; the block
  // then has nothing in flight since every item yields a result.
  task automatic wait_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (verdict_q.size() != 0) @(negedge clk);
  endtask

  // APB write of pattern_length, then a read back of the same register.
  task automatic write_length(logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LENGTH_ADDR;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    pwrite  <= 1'b0;    // read setup follows the write access directly
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== 32'(value[5:0])) begin
      $display("%0t: pattern_length read mismatch: expected %0d actual %0d",
               $time, value[5:0], prdata);
      errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // mostly a few letters so that patterns and texts meet often
  function automatic logic [7:0] pick_symbol();
    case ($urandom_range(9))
      0, 1, 2, 3: return SYM_A;
      4, 5, 6:    return SYM_B;
      7:          return SYM_C;
      default:    return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_token();
    return ($urandom_range(4) == 0) ? ANY_SYMBOL : pick_symbol();
  endfunction

  // One text over the first len tokens of the stimulus pattern. Well-formed
  // texts follow the pattern (star repeats 0..3), some get one byte spoiled.
  // Ends on a last byte or an end request; noise may land in the middle.
  task automatic send_text(int len, bit well_formed);
    logic [7:0] text_q[$];
    int         reps;
    bit         end_on_last;
    if (well_formed) begin
      for (int i = 0; i < len; i++) begin
        reps = stim_star[i] ? $urandom_range(0, 3) : 1;
        repeat (reps) text_q.push_back(stim_sym[i] == ANY_SYMBOL ? pick_symbol() : stim_sym[i]);
      end
      if ($urandom_range(99) < 20) begin
        if (text_q.size() == 0) text_q.push_back(pick_symbol());
        else text_q[$urandom_range(text_q.size() - 1)] = pick_symbol();
      end
    end else begin
      repeat ($urandom_range(0, 6)) text_q.push_back(pick_symbol());
    end
    end_on_last = ($urandom_range(99) < 75);
    foreach (text_q[i]) begin
      if ($urandom_range(99) < 4) begin
        if ($urandom_range(1)) send_item(random_item(REQ_UNUSED));
        else send_load(5'($urandom), pick_token(), 1'($urandom_range(1)));
      end
      send_byte(text_q[i], end_on_last && i == text_q.size() - 1);
    end
    if (text_q.size() == 0 || !end_on_last) send_end();
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Length 0 after reset: only the empty text matches. Store is never read.
  task automatic test_reset_state();
    send_end();
    send_byte(SYM_A, 1'b1);
    send_item(random_item(REQ_UNUSED));
    send_byte(8'hFF, 1'b0);
    send_end();               // ends a one-byte text early
  endtask

  // pattern a .* b c*, plus extreme store positions and symbols
  task automatic test_basic_patterns();
    send_load(5'd31, 8'hFF, 1'b1);
    send_load(5'd30, 8'h00, 1'b0);
    send_load(5'd0, SYM_A, 1'b0);
    send_load(5'd1, ANY_SYMBOL, 1'b1);
    send_load(5'd2, SYM_B, 1'b0);
    send_load(5'd3, SYM_C, 1'b1);
    wait_results();
    write_length(32'd4);
    send_byte(SYM_A, 1'b0);   // "ab": dot-star and c-star both empty
    send_byte(SYM_B, 1'b1);
    send_byte(SYM_A, 1'b0);   // dot-star eats extreme bytes
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(SYM_B, 1'b1);
    send_byte(SYM_A, 1'b0);   // trailing starred c repeats
    send_byte(SYM_B, 1'b0);
    send_byte(SYM_C, 1'b0);
    send_byte(SYM_C, 1'b1);
    send_byte(SYM_A, 1'b0);   // ended early: no b yet
    send_end();
    send_end();               // empty text against a non-empty pattern
  endtask

  // token 2 becomes 'd' between bytes; active set is kept
  task automatic test_load_mid_text();
    send_byte(SYM_A, 1'b0);
    send_load(5'd2, SYM_D, 1'b0);
    send_byte(SYM_D, 1'b1);
  endtask

  // length shrinks between bytes of one text; positions carry over
  task automatic test_length_change_mid_text();
    send_byte(SYM_A, 1'b0);
    wait_results();
    write_length(32'd1);
    send_end();
  endtask

  // Random phases: load a pattern, set the length, stream texts. Phase 0
  // fills the whole store (length 32), phase 1 uses the largest length
  // value; a stretch of phases runs without idling.
  task automatic test_random_texts();
    int          phase;
    int          plen;
    int          first;
    logic [31:0] wval;
    phase = 0;
    first = text_items;
    while (text_items - first < TEXT_ITEMS) begin
      idle_pct = (phase == 2 || phase == 3) ? 0 : 23;
      if (phase <= 1) begin
        plen = PATTERN_MAX;
      end else begin
        case ($urandom_range(9))
          0:       plen = PATTERN_MAX;
          1:       plen = 0;
          default: plen = $urandom_range(1, 8);
        endcase
      end
      for (int i = 0; i < plen; i++)
        send_load(5'(i), pick_token(), $urandom_range(99) < 35);
      wait_results();
      wval = $urandom;
      if (phase == 1) wval[5:0] = 6'd63;
      else if (plen == PATTERN_MAX && $urandom_range(1)) wval[5:0] = 6'($urandom_range(33, 63));
      else wval[5:0] = 6'(plen);
      if ($urandom_range(9) != 0) wval[31:6] = '0;
      write_length(wval);
      // long patterns get few texts so that the short phases keep their share
      repeat ((phase <= 1) ? $urandom_range(2, 5) : $urandom_range(5, 25))
        send_text(plen, $urandom_range(99) < 80);
      phase++;
    end
    idle_pct = 23;
  endtask

  initial begin
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    idle_pct  = 23;
    rst_n     = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_basic_patterns();
    test_load_mid_text();
    test_length_change_mid_text();
    test_random_texts();

    wait_results();
    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("wildcard_star_regex_matcher regression: pass");
    end else begin
      $display("wildcard_star_regex_matcher regression: fail");
    end
    $finish;
  end

endmodule
